// ----- design/lrl_pkg.sv -----
// Shared constants, codes and controller/datapath command type for the LRU replacement list.
`default_nettype none
package lrl_pkg;

	localparam int CAPACITY  = 16;
	localparam int KEY_BITS  = 16;
	localparam int CNT_BITS  = $clog2(CAPACITY + 1);
	localparam int SLOT_BITS = $clog2(CAPACITY);
	localparam int MODE_BITS = 2;

	localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_EVICT  = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_ERASE  = 2'd2;

	typedef struct packed {
		logic load;   // capture word and match vector
		logic exec;   // apply shift/write and post result
	} cmd_t;

endpackage
`default_nettype wire

// ----- design/lrl_ctrl.sv -----
// Controller: two-state sequencer issuing load/exec commands to the datapath.
`default_nettype none
module lrl_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	output lrl_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ----- design/lrl_dpath.sv -----
// Datapath: slot registers, parallel key compare, shift/append update and result registers.
`default_nettype none
module lrl_dpath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire lrl_pkg::cmd_t                  cmd,
	input  wire logic [lrl_pkg::MODE_BITS-1:0]  mode,
	input  wire logic [lrl_pkg::KEY_BITS-1:0]   key,
	output logic                                done,
	output logic                                ok,
	output logic [lrl_pkg::KEY_BITS-1:0]        victim_key,
	output logic [lrl_pkg::CNT_BITS-1:0]        occupancy,
	output logic                                full_flag
);

	logic [lrl_pkg::KEY_BITS-1:0]  slot_q [lrl_pkg::CAPACITY];
	logic [lrl_pkg::CNT_BITS-1:0]  count_q, count_d;

	logic [lrl_pkg::CAPACITY-1:0]  hit, tail_mask;
	logic [lrl_pkg::CAPACITY-1:0]  tail_s1;
	logic                          found_s1;
	logic [lrl_pkg::MODE_BITS-1:0] mode_s1;
	logic [lrl_pkg::KEY_BITS-1:0]  key_s1;

	logic [lrl_pkg::CAPACITY-1:0]  shift_en;
	logic                          wr_en;
	logic [lrl_pkg::SLOT_BITS-1:0] wr_idx;
	logic                          ok_d, full_d;
	logic [lrl_pkg::KEY_BITS-1:0]  victim_d;

	logic                          done_q, ok_q, full_q;
	logic [lrl_pkg::KEY_BITS-1:0]  victim_q;

	// compare key against every occupied slot
	always_comb begin
		for (int i = 0; i < lrl_pkg::CAPACITY; i++) begin
			hit[i] = (lrl_pkg::CNT_BITS'(i) < count_q) && (slot_q[i] == key);
		end
		// tail_mask[i]: hit at or below i, i.e. slot i closes the gap
		for (int i = 0; i < lrl_pkg::CAPACITY; i++) begin
			tail_mask[i] = 1'b0;
			for (int j = 0; j <= i; j++) begin
				tail_mask[i] = tail_mask[i] | hit[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_s1  <= mode;
			key_s1   <= key;
			tail_s1  <= tail_mask;
			found_s1 <= |hit;
		end
	end

	// update decode
	always_comb begin
		count_d  = count_q;
		shift_en = '0;
		wr_en    = 1'b0;
		wr_idx   = count_q[lrl_pkg::SLOT_BITS-1:0];
		ok_d     = 1'b0;
		full_d   = 1'b0;
		victim_d = '0;
		case (mode_s1)
			lrl_pkg::MODE_INSERT: begin
				if (found_s1) begin
					shift_en = tail_s1;
					wr_en    = 1'b1;
					wr_idx   = lrl_pkg::SLOT_BITS'(count_q - 1'b1);
					ok_d     = 1'b1;
				end else if (count_q < lrl_pkg::CNT_BITS'(lrl_pkg::CAPACITY)) begin
					wr_en    = 1'b1;
					count_d  = count_q + 1'b1;
					ok_d     = 1'b1;
				end else begin
					full_d   = 1'b1;
				end
			end
			lrl_pkg::MODE_EVICT: begin
				if (count_q != '0) begin
					shift_en = '1;
					victim_d = slot_q[0];
					count_d  = count_q - 1'b1;
					ok_d     = 1'b1;
				end
			end
			lrl_pkg::MODE_ERASE: begin
				if (found_s1) begin
					shift_en = tail_s1;
					count_d  = count_q - 1'b1;
					ok_d     = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// slot row: shift toward slot 0; on insert, write the key at the tail
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			for (int i = 0; i < lrl_pkg::CAPACITY; i++) begin
				if (wr_en && (wr_idx == lrl_pkg::SLOT_BITS'(i))) begin
					slot_q[i] <= key_s1;
				end else if (shift_en[i] && (i < lrl_pkg::CAPACITY - 1)) begin
					slot_q[i] <= slot_q[(i + 1) % lrl_pkg::CAPACITY];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			if (cmd.exec) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			ok_q     <= ok_d;
			full_q   <= full_d;
			victim_q <= victim_d;
		end
	end

	assign done       = done_q;
	assign ok         = ok_q;
	assign full_flag  = full_q;
	assign victim_key = victim_q;
	assign occupancy  = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lrl_pkg::CNT_BITS'(lrl_pkg::CAPACITY))
		else $error("occupancy above capacity");

	a_keys_unique: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> $onehot0(hit))
		else $error("key matched in more than one slot");

	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> done_q)
		else $error("exec without result strobe");

	a_ok_full: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(ok_q && full_q))
		else $error("result both accepted and dropped");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> (count_q == $past(count_q) || count_q == $past(count_q) + 1'b1
			|| count_q == $past(count_q) - 1'b1))
		else $error("occupancy moved by more than one");

endmodule
`default_nettype wire

// ----- design/lru_replacement_list.sv -----
// Top level of the LRU replacement list: controller plus datapath.
//
//  channel  | handshake          | words
//  ---------+--------------------+---------------------------------------
//  command  | start / busy       | mode, key
//  result   | done (1-cycle)     | ok, victim_key, occupancy, full_flag
//
// Each word is accepted in ST_IDLE, where the accept edge registers the 16-way key
// compare; in ST_EXEC the shift/append is applied to the slot row and the result posted.
// done is high for the cycle after that; a new word may be accepted in it.
// arst_n clears the occupancy and the sequencer; slot contents need no reset.
// The receiver cannot stall: each result is shown once, for one cycle.
`default_nettype none
module lru_replacement_list (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [lrl_pkg::MODE_BITS-1:0]  mode,
	input  wire logic [lrl_pkg::KEY_BITS-1:0]   key,
	output logic                                done,
	output logic                                ok,
	output logic [lrl_pkg::KEY_BITS-1:0]        victim_key,
	output logic [lrl_pkg::CNT_BITS-1:0]        occupancy,
	output logic                                full_flag
);

	lrl_pkg::cmd_t cmd;

	lrl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	lrl_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.mode       (mode),
		.key        (key),
		.done       (done),
		.ok         (ok),
		.victim_key (victim_key),
		.occupancy  (occupancy),
		.full_flag  (full_flag)
	);

endmodule
`default_nettype wire
